### hw/rtl/pidaw_pkg.sv
// pidaw_pkg: shared types and constants of the pid controller with anti-windup
// word layouts of both channels, register indexes and reset values
// no dependencies
package pidaw_pkg;

    // data word format, signed fixed point
    localparam int DataW      = 32;
    localparam int FracBits   = 16;
    localparam int PeriodFrac = 16;

    // configuration port
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    // register widths
    localparam int PeriodW = 16;
    localparam int WlimW   = 31;
    localparam int AlphaW  = 17;

    // unity weight of the derivative filter
    localparam logic [AlphaW-1:0] AlphaOne = AlphaW'(65536);

    // register reset values
    localparam logic signed [DataW-1:0] PropGainRst  = 32'sd65536;
    localparam logic signed [DataW-1:0] IntegGainRst = 32'sd0;
    localparam logic signed [DataW-1:0] DerivGainRst = 32'sd0;
    localparam logic [PeriodW-1:0]      PeriodRst    = 16'd655;
    localparam logic [WlimW-1:0]        WlimRst      = 31'd655360;
    localparam logic [AlphaW-1:0]       AlphaRst     = 17'd65536;
    localparam logic signed [DataW-1:0] DriveMinRst  = -32'sd6553600;
    localparam logic signed [DataW-1:0] DriveMaxRst  = 32'sd6553600;

    // register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_PERIOD     = 3'd3,
        CFG_WINDUP     = 3'd4,
        CFG_ALPHA      = 3'd5,
        CFG_DRIVE_MIN  = 3'd6,
        CFG_DRIVE_MAX  = 3'd7
    } t_cfg_idx;

    // one sample word
    typedef struct packed {
        logic signed [DataW-1:0] target;
        logic signed [DataW-1:0] measured;
        logic                    start_req;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic signed [DataW-1:0] drive;
        logic signed [DataW-1:0] err_value;
        logic                    clamped;
    } t_out_word;

endpackage

### hw/rtl/pidaw_in_if.sv
// pidaw_in_if: valid/ready channel that carries sample words
// depends on pidaw_pkg
interface pidaw_in_if;
    logic                 valid;
    logic                 ready;
    pidaw_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/pidaw_out_if.sv
// pidaw_out_if: valid/ready channel that carries result words
// depends on pidaw_pkg
interface pidaw_out_if;
    logic                 valid;
    logic                 ready;
    pidaw_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/pid_controller_antiwindup.sv
// pid_controller_antiwindup: positional pid controller, q16.16, integral clamp
// depends on pidaw_pkg, pidaw_in_if, pidaw_out_if
//
// channel   dir  modport  word fields
// i_smp     in   sink     target, measured, start_req
// o_res     out  source   drive, err_value, clamped
// cfg       in   -        i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// each sample runs from acceptance to the result register through the error and
// difference steps, then the five products pass one after another through a
// single 32x32 multiplier (operand, multiply, round, accumulate steps each),
// then the clamp and output steps. i_smp.ready is high only when idle, so a
// new sample is taken only once the previous one has left the output step.
// the result register lets the next sample enter while a result waits.
// synchronous active-low reset restores register defaults and clears state.
module pid_controller_antiwindup (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pidaw_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  logic [pidaw_pkg::CfgDataW-1:0]        i_cfg_data,
    pidaw_in_if.sink                              i_smp,
    pidaw_out_if.source                           o_res
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_OPS,
        ST_MUL,
        ST_RND,
        ST_ACC,
        ST_CLAMP,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        STEP_INTEG,
        STEP_FILT,
        STEP_PROP,
        STEP_INTGAIN,
        STEP_DERIV
    } t_step;

    // saturate a grown sum to one data word
    function automatic logic signed [31:0] sat_dw(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // magnitude of a 33-bit signed value, known to fit 32 bits
    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    // configuration registers
    logic signed [31:0] r_kp, r_ki, r_kd, r_dmin, r_dmax;
    logic [pidaw_pkg::PeriodW-1:0] r_period;
    logic [pidaw_pkg::WlimW-1:0]   r_wlim;
    logic [pidaw_pkg::AlphaW-1:0]  r_alpha;

    // sequencer and datapath registers
    t_state             r_state;
    t_step              r_step;
    logic signed [31:0] r_target, r_measured;
    logic               r_start;
    logic signed [31:0] r_err, r_diff, r_integ, r_last, r_df;
    logic [31:0]        r_opa, r_opb;
    logic               r_neg, r_prod_neg;
    logic [63:0]        r_prod;
    logic signed [31:0] r_term;
    logic signed [33:0] r_sum;
    logic signed [31:0] r_raw, r_drive;
    logic               r_clamped;
    pidaw_pkg::t_out_word r_out;
    logic               r_out_valid;

    // combinational helpers
    logic signed [32:0] n_a, n_b;
    logic [pidaw_pkg::AlphaW-1:0] w_alpha;
    logic [64:0]        w_rsum;
    logic [48:0]        w_res, w_limit, w_resc;
    logic signed [32:0] w_tpos, w_term;
    logic signed [31:0] w_integ_sat, w_wlim, w_nwlim, w_dhi;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= pidaw_pkg::PropGainRst;
            r_ki     <= pidaw_pkg::IntegGainRst;
            r_kd     <= pidaw_pkg::DerivGainRst;
            r_period <= pidaw_pkg::PeriodRst;
            r_wlim   <= pidaw_pkg::WlimRst;
            r_alpha  <= pidaw_pkg::AlphaRst;
            r_dmin   <= pidaw_pkg::DriveMinRst;
            r_dmax   <= pidaw_pkg::DriveMaxRst;
        end else if (i_cfg_we) begin
            unique case (pidaw_pkg::t_cfg_idx'(i_cfg_idx))
                pidaw_pkg::CFG_PROP_GAIN:  r_kp     <= i_cfg_data;
                pidaw_pkg::CFG_INTEG_GAIN: r_ki     <= i_cfg_data;
                pidaw_pkg::CFG_DERIV_GAIN: r_kd     <= i_cfg_data;
                pidaw_pkg::CFG_PERIOD:     r_period <= i_cfg_data[pidaw_pkg::PeriodW-1:0];
                pidaw_pkg::CFG_WINDUP:     r_wlim   <= i_cfg_data[pidaw_pkg::WlimW-1:0];
                pidaw_pkg::CFG_ALPHA:      r_alpha  <= i_cfg_data[pidaw_pkg::AlphaW-1:0];
                pidaw_pkg::CFG_DRIVE_MIN:  r_dmin   <= i_cfg_data;
                pidaw_pkg::CFG_DRIVE_MAX:  r_dmax   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // filter weight above unity acts as unity
    assign w_alpha = (r_alpha > pidaw_pkg::AlphaOne) ? pidaw_pkg::AlphaOne : r_alpha;

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_step)
            STEP_INTEG: begin
                n_a = 33'(r_err);
                n_b = $signed({17'b0, r_period});
            end
            STEP_FILT: begin
                n_a = $signed({16'b0, w_alpha});
                n_b = 33'(r_diff) - 33'(r_df);
            end
            STEP_PROP: begin
                n_a = 33'(r_kp);
                n_b = 33'(r_err);
            end
            STEP_INTGAIN: begin
                n_a = 33'(r_ki);
                n_b = 33'(r_integ);
            end
            STEP_DERIV: begin
                n_a = 33'(r_kd);
                n_b = 33'(r_df);
            end
            default: begin
                n_a = '0;
                n_b = '0;
            end
        endcase
    end

    // round magnitude to nearest, saturate, then apply sign
    always_comb begin
        w_rsum  = {1'b0, r_prod} + 65'(1 << (pidaw_pkg::FracBits - 1));
        w_res   = w_rsum[64:pidaw_pkg::FracBits];
        w_limit = r_prod_neg ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
        w_resc  = (w_res > w_limit) ? w_limit : w_res;
        w_tpos  = $signed({1'b0, w_resc[31:0]});
        w_term  = r_prod_neg ? -w_tpos : w_tpos;
    end

    // integral update with windup bound
    always_comb begin
        w_wlim      = $signed({1'b0, r_wlim});
        w_nwlim     = -w_wlim;
        w_integ_sat = sat_dw(34'(r_integ) + 34'(r_term));
    end

    // upper drive bound first, then lower
    assign w_dhi = (r_raw > r_dmax) ? r_dmax : r_raw;

    // sequencer, datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_INTEG;
            r_integ     <= '0;
            r_last      <= '0;
            r_df        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_smp.valid) begin
                        r_target   <= i_smp.data.target;
                        r_measured <= i_smp.data.measured;
                        r_start    <= i_smp.data.start_req;
                        if (i_smp.data.start_req) begin
                            r_integ <= '0;
                            r_last  <= '0;
                            r_df    <= '0;
                        end
                        r_state <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    r_err   <= sat_dw(34'(r_target) - 34'(r_measured));
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_diff  <= r_start ? 32'sd0 : sat_dw(34'(r_err) - 34'(r_last));
                    r_last  <= r_err;
                    r_step  <= STEP_INTEG;
                    r_state <= ST_OPS;
                end
                ST_OPS: begin
                    r_opa   <= mag33(n_a);
                    r_opb   <= mag33(n_b);
                    r_neg   <= n_a[32] ^ n_b[32];
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod     <= r_opa * r_opb;
                    r_prod_neg <= r_neg;
                    r_state    <= ST_RND;
                end
                ST_RND: begin
                    r_term  <= w_term[31:0];
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    unique case (r_step)
                        STEP_INTEG: begin
                            if (w_integ_sat > w_wlim) begin
                                r_integ <= w_wlim;
                            end else if (w_integ_sat < w_nwlim) begin
                                r_integ <= w_nwlim;
                            end else begin
                                r_integ <= w_integ_sat;
                            end
                        end
                        STEP_FILT:    r_df  <= sat_dw(34'(r_df) + 34'(r_term));
                        STEP_PROP:    r_sum <= 34'(r_term);
                        STEP_INTGAIN: r_sum <= r_sum + 34'(r_term);
                        STEP_DERIV:   r_raw <= sat_dw(r_sum + 34'(r_term));
                        default: ;
                    endcase
                    if (r_step == STEP_DERIV) begin
                        r_state <= ST_CLAMP;
                    end else begin
                        r_step  <= t_step'(r_step + 3'd1);
                        r_state <= ST_OPS;
                    end
                end
                ST_CLAMP: begin
                    r_drive   <= (w_dhi < r_dmin) ? r_dmin : w_dhi;
                    r_clamped <= ((w_dhi < r_dmin) ? r_dmin : w_dhi) != r_raw;
                    r_state   <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out.drive     <= r_drive;
                        r_out.err_value <= r_err;
                        r_out.clamped   <= r_clamped;
                        r_out_valid     <= 1'b1;
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // channel outputs
    assign i_smp.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

### hw/rtl/pidaw_checker.sv
// pidaw_checker: port-level assertions for pid_controller_antiwindup
// depends on pidaw_pkg; bound to the top level at the end of this file
module pidaw_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input pidaw_pkg::t_out_word i_out_data
);

    // one sample at a time: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready after accepting a word");

    // ready only drops because a word was taken
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid))
        else $error("input ready dropped without an accepted word");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

### tb/pid_controller_antiwindup_tb.sv
// pid_controller_antiwindup_tb: self-checking bench of the pid controller with anti-windup
// a table of directed samples, then register settings with random sample runs,
// each result checked against its table value or a fixed-point predictor; needs pidaw_pkg and the interfaces
module pid_controller_antiwindup_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_VECS = 20;
    localparam int NUM_PHASES = 15;
    localparam int HOLD_CYCLES = 300;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam longint ALPHA_UNITY = 64'sd65536;

    // directed sample with an optional hand-written result
    typedef struct packed {
        logic [31:0] tgt;
        logic [31:0] meas;
        logic        st;
        logic        known;
        logic [31:0] drv;
        logic [31:0] err;
        logic        clp;
    } t_vec;

    // with reset settings the drive is the error limited to +/-100.0
    localparam t_vec VECS [NUM_VECS] = '{
        '{32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd0, 32'sd0, 1'b0},
        '{32'sd65536, 32'sd0, 1'b0, 1'b1, 32'sd65536, 32'sd65536, 1'b0},
        '{32'sd0, 32'sd65536, 1'b0, 1'b1, -32'sd65536, -32'sd65536, 1'b0},
        '{32'sd6553600, 32'sd0, 1'b0, 1'b1, 32'sd6553600, 32'sd6553600, 1'b0},
        '{32'sd6553601, 32'sd0, 1'b0, 1'b1, 32'sd6553600, 32'sd6553601, 1'b1},
        '{-32'sd6553600, 32'sd0, 1'b0, 1'b1, -32'sd6553600, -32'sd6553600, 1'b0},
        '{-32'sd6553601, 32'sd0, 1'b0, 1'b1, -32'sd6553600, -32'sd6553601, 1'b1},
        '{32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1, 32'sd6553600, 32'h7fff_ffff, 1'b1},
        '{32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1, -32'sd6553600, 32'h8000_0000, 1'b1},
        '{32'h7fff_ffff, 32'sd0, 1'b0, 1'b1, 32'sd6553600, 32'h7fff_ffff, 1'b1},
        '{32'h8000_0000, 32'sd1, 1'b0, 1'b1, -32'sd6553600, 32'h8000_0000, 1'b1},
        '{32'h7fff_ffff, 32'hffff_ffff, 1'b0, 1'b1, 32'sd6553600, 32'h7fff_ffff, 1'b1},
        '{32'hffff_ffff, 32'h7fff_ffff, 1'b0, 1'b1, -32'sd6553600, 32'h8000_0000, 1'b1},
        '{32'h5555_5555, 32'h5555_5555, 1'b0, 1'b1, 32'sd0, 32'sd0, 1'b0},
        '{32'haaaa_aaaa, 32'haaaa_aaaa, 1'b1, 1'b1, 32'sd0, 32'sd0, 1'b0},
        '{32'sd1, 32'sd0, 1'b0, 1'b1, 32'sd1, 32'sd1, 1'b0},
        '{32'sd0, 32'sd1, 1'b0, 1'b1, -32'sd1, -32'sd1, 1'b0},
        '{32'sd123456, -32'sd654321, 1'b1, 1'b1, 32'sd777777, 32'sd777777, 1'b0},
        '{32'h1234_5678, 32'h0fed_cba9, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0},
        '{-32'sd300000, 32'sd250000, 1'b0, 1'b0, 32'sd0, 32'sd0, 1'b0}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [pidaw_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [pidaw_pkg::CfgDataW-1:0] i_cfg_data;

    pidaw_in_if  smp_if ();
    pidaw_out_if res_if ();

    pid_controller_antiwindup DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_if),
        .o_res      (res_if)
    );

    // register copies and loop state of the predictor
    longint cfg_kp, cfg_ki, cfg_kd, cfg_period, cfg_wlim, cfg_alpha, cfg_dmin, cfg_dmax;
    longint acc, prev_err, dfilt;

    pidaw_pkg::t_out_word pending_drives [$];
    int        mismatches = 0;
    int        leftover;
    int        cycle_cnt = 0;
    bit        idle_on;
    int        hold_reqs;

    // random walk of the well-formed sample runs
    longint walk_target, walk_meas;
    int     run_left;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint sat32(input longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    // exact product, magnitude rounded half away from zero, then saturated
    function automatic longint mul_round(input longint a, input longint b, input int sh);
        logic         neg;
        logic [63:0]  ua, ub;
        logic [127:0] prod, lim;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        prod = (prod + (128'd1 << (sh - 1))) >> sh;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (prod > lim) prod = lim;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // one control step: error, clamped integral, filtered difference, bounded drive
    function automatic pidaw_pkg::t_out_word compute_drive(input pidaw_pkg::t_in_word w);
        longint    err, diff, raw, out_v, a_eff;
        pidaw_pkg::t_out_word r;
        a_eff = (cfg_alpha > ALPHA_UNITY) ? ALPHA_UNITY : cfg_alpha;
        if (w.start_req) begin
            acc = 0;
            prev_err = 0;
            dfilt = 0;
        end
        err = sat32(longint'($signed(w.target)) - longint'($signed(w.measured)));
        acc = sat32(acc + mul_round(err, cfg_period, pidaw_pkg::PeriodFrac));
        if (acc > cfg_wlim) acc = cfg_wlim;
        if (acc < -cfg_wlim) acc = -cfg_wlim;
        diff = w.start_req ? 0 : sat32(err - prev_err);
        dfilt = sat32(dfilt + mul_round(a_eff, diff - dfilt, pidaw_pkg::PeriodFrac));
        raw = sat32(mul_round(cfg_kp, err, pidaw_pkg::FracBits)
                    + mul_round(cfg_ki, acc, pidaw_pkg::FracBits)
                    + mul_round(cfg_kd, dfilt, pidaw_pkg::FracBits));
        out_v = raw;
        if (out_v > cfg_dmax) out_v = cfg_dmax;
        if (out_v < cfg_dmin) out_v = cfg_dmin;
        prev_err = err;
        r.drive = out_v[31:0];
        r.err_value = err[31:0];
        r.clamped = (out_v != raw);
        return r;
    endfunction

    // register write, called at a falling edge with the block idle
    task automatic write_reg(input pidaw_pkg::t_cfg_idx idx, input logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        case (idx)
            pidaw_pkg::CFG_PROP_GAIN:  cfg_kp = longint'($signed(v));
            pidaw_pkg::CFG_INTEG_GAIN: cfg_ki = longint'($signed(v));
            pidaw_pkg::CFG_DERIV_GAIN: cfg_kd = longint'($signed(v));
            pidaw_pkg::CFG_PERIOD:     cfg_period = longint'(v[pidaw_pkg::PeriodW-1:0]);
            pidaw_pkg::CFG_WINDUP:     cfg_wlim = longint'(v[pidaw_pkg::WlimW-1:0]);
            pidaw_pkg::CFG_ALPHA:      cfg_alpha = longint'(v[pidaw_pkg::AlphaW-1:0]);
            pidaw_pkg::CFG_DRIVE_MIN:  cfg_dmin = longint'($signed(v));
            pidaw_pkg::CFG_DRIVE_MAX:  cfg_dmax = longint'($signed(v));
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] kp, ki, kd, per, wl, al, lo, hi);
        write_reg(pidaw_pkg::CFG_PROP_GAIN, kp);
        write_reg(pidaw_pkg::CFG_INTEG_GAIN, ki);
        write_reg(pidaw_pkg::CFG_DERIV_GAIN, kd);
        write_reg(pidaw_pkg::CFG_PERIOD, per);
        write_reg(pidaw_pkg::CFG_WINDUP, wl);
        write_reg(pidaw_pkg::CFG_ALPHA, al);
        write_reg(pidaw_pkg::CFG_DRIVE_MIN, lo);
        write_reg(pidaw_pkg::CFG_DRIVE_MAX, hi);
        i_cfg_we <= 1'b0;
    endtask

    // mostly small gains around zero, sometimes any word
    function automatic logic [31:0] pick_gain(input int unsigned span);
        if ($urandom_range(0, 3) != 0) return 32'($urandom_range(0, 2 * span) - span);
        return $urandom;
    endfunction

    task automatic random_settings();
        logic [31:0] per, wl, al, lo, hi;
        case ($urandom_range(0, 4))
            0: per = 32'd0;
            1: per = 32'd65535;
            2: per = $urandom;
            default: per = $urandom_range(1, 3000);
        endcase
        case ($urandom_range(0, 3))
            0: wl = $urandom;
            1: wl = 32'd0;
            default: wl = $urandom_range(0, 50 * 65536);
        endcase
        case ($urandom_range(0, 4))
            0: al = $urandom;
            1: al = 32'd65536;
            default: al = $urandom_range(0, 65536);
        endcase
        case ($urandom_range(0, 5))
            0: begin
                lo = $urandom;
                hi = $urandom;
            end
            1: begin
                // lower bound above upper bound
                lo = $urandom_range(0, 100 * 65536);
                hi = 32'(0 - $urandom_range(0, 100 * 65536));
            end
            default: begin
                lo = 32'(0 - $urandom_range(0, 200 * 65536));
                hi = $urandom_range(0, 200 * 65536);
            end
        endcase
        apply_settings(pick_gain(4 * 65536), pick_gain(2 * 65536), pick_gain(65536),
                       per, wl, al, lo, hi);
    endtask

    // mostly runs that start clean and track a setpoint, the rest noise
    task automatic next_sample(output pidaw_pkg::t_in_word w);
        if ($urandom_range(0, 99) < 15) begin
            w.target = $urandom;
            w.measured = $urandom;
            w.start_req = 1'($urandom_range(0, 1));
        end else begin
            w.start_req = 1'b0;
            if (run_left == 0) begin
                run_left = $urandom_range(5, 60);
                walk_target = longint'($urandom_range(0, 100 * 65536)) - 50 * 65536;
                walk_meas = longint'($urandom_range(0, 100 * 65536)) - 50 * 65536;
                // a few runs go without the start flag
                w.start_req = ($urandom_range(0, 9) != 0);
            end else if ($urandom_range(0, 15) == 0) begin
                walk_target = longint'($urandom_range(0, 100 * 65536)) - 50 * 65536;
            end
            run_left--;
            walk_meas = walk_meas + (walk_target - walk_meas) / 8
                        + longint'($urandom_range(0, 65536)) - 32768;
            w.target = walk_target[31:0];
            w.measured = walk_meas[31:0];
        end
    endtask

    // offer one word, called at a falling edge; valid stays up unless a gap follows
    task automatic send_sample(input pidaw_pkg::t_in_word w, input bit known,
                               input pidaw_pkg::t_out_word typed);
        pidaw_pkg::t_out_word pred;
        smp_if.valid <= 1'b1;
        smp_if.data <= w;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        pred = compute_drive(w);
        pending_drives.push_back(known ? typed : pred);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while (pending_drives.size() != 0 && n < 20000) begin
            @(negedge i_clk);
            n++;
        end
    endtask

    // result side: random stall bursts, and a long hold on request
    initial begin
        int stall;
        int seen;
        stall = 0;
        seen = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != seen) begin
                seen = hold_reqs;
                stall = HOLD_CYCLES;
            end else if (stall == 0 && idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 7);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // compare each accepted result word with the oldest prediction
    pidaw_pkg::t_out_word want;
    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready) begin
            if (pending_drives.size() == 0) begin
                $error("unexpected result word: drive %0d err_value %0d",
                       res_if.data.drive, res_if.data.err_value);
                mismatches++;
            end else begin
                want = pending_drives.pop_front();
                if (res_if.data.drive !== want.drive) begin
                    $error("drive: expected %0d, got %0d", want.drive, res_if.data.drive);
                    mismatches++;
                end
                if (res_if.data.err_value !== want.err_value) begin
                    $error("err_value: expected %0d, got %0d",
                           want.err_value, res_if.data.err_value);
                    mismatches++;
                end
                if (res_if.data.clamped !== want.clamped) begin
                    $error("clamped: expected %0d, got %0d", want.clamped, res_if.data.clamped);
                    mismatches++;
                end
            end
        end
    end

    // main sequence
    initial begin
        pidaw_pkg::t_in_word  w;
        pidaw_pkg::t_out_word typed;
        int        n_items;
        leftover = 0;
        hold_reqs = 0;
        idle_on = 1'b1;
        run_left = 0;
        walk_target = 0;
        walk_meas = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = pidaw_pkg::CFG_PROP_GAIN;
        i_cfg_data = '0;
        smp_if.valid = 1'b0;
        smp_if.data = '0;

        // reset values of the predictor
        cfg_kp = longint'(pidaw_pkg::PropGainRst);
        cfg_ki = longint'(pidaw_pkg::IntegGainRst);
        cfg_kd = longint'(pidaw_pkg::DerivGainRst);
        cfg_period = longint'(pidaw_pkg::PeriodRst);
        cfg_wlim = longint'(pidaw_pkg::WlimRst);
        cfg_alpha = longint'(pidaw_pkg::AlphaRst);
        cfg_dmin = longint'(pidaw_pkg::DriveMinRst);
        cfg_dmax = longint'(pidaw_pkg::DriveMaxRst);
        acc = 0;
        prev_err = 0;
        dfilt = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table under reset settings
        for (int i = 0; i < NUM_VECS; i++) begin
            w.target = VECS[i].tgt;
            w.measured = VECS[i].meas;
            w.start_req = VECS[i].st;
            typed.drive = VECS[i].drv;
            typed.err_value = VECS[i].err;
            typed.clamped = VECS[i].clp;
            send_sample(w, VECS[i].known, typed);
        end
        smp_if.valid <= 1'b0;
        wait_drained();

        // settings phases: two extreme sets, a moderate set, then random settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_settings(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd65535,
                                  32'h7fff_ffff, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
                // zero period, no windup room, alpha above unity, bounds crossed
                1: apply_settings(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd0,
                                  32'd0, 32'h0001_ffff, 32'd65536, 32'hffff_0000);
                2: apply_settings(32'd131072, 32'd32768, 32'd98304, 32'd655,
                                  32'd655360, 32'd16384, 32'hff9c_0000, 32'd6553600);
                default: random_settings();
            endcase
            idle_on <= (p >= NUM_PHASES - 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            @(negedge i_clk);
            n_items = (p < 3) ? 40 : 100;
            for (int i = 0; i < n_items; i++) begin
                // long hold on the result side while samples keep coming
                if (p == 4 && i == 5) hold_reqs <= hold_reqs + 1;
                next_sample(w);
                send_sample(w, 1'b0, '0);
            end
            smp_if.valid <= 1'b0;
            wait_drained();
        end

        repeat (60) @(posedge i_clk);
        leftover = pending_drives.size();
        if (leftover != 0) $error("%0d result words never arrived", leftover);
        if (mismatches == 0 && leftover == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### pid_controller_antiwindup.f
hw/rtl/pidaw_pkg.sv
hw/rtl/pidaw_in_if.sv
hw/rtl/pidaw_out_if.sv
hw/rtl/pid_controller_antiwindup.sv
hw/rtl/pidaw_checker.sv
tb/pid_controller_antiwindup_tb.sv
